/* sv/lru_open_page_tracker_macros.svh */
// assertion macros for the lru open page tracker
// no dependencies; included by the rtl files that check their own logic
`ifndef LRU_OPEN_PAGE_TRACKER_MACROS_SVH
`define LRU_OPEN_PAGE_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// checked at every rising edge, skipped while reset is high
`define LOPT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lopt assertion failed");

// checked at every rising edge, reset included
`define LOPT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("lopt assertion failed");

`else

`define LOPT_ASSERT(label, clk, rst, prop)
`define LOPT_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* sv/lopt_pkg.sv */
// shared types and constants of the lru open page tracker
// no dependencies; imported by every module of the block
package lopt_pkg;

   // list geometry
   localparam int DEPTH   = 4;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FIELD_W = 16;
   localparam int KEY_W   = 2 * FIELD_W;
   localparam int OCC_W   = 3;

   // request kinds
   typedef enum logic {
      OP_OPEN  = 1'b0,
      OP_CLOSE = 1'b1
   } opcode_type;

   // controller states
   typedef enum logic {
      ST_EMPTY,
      ST_HOLD
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
   } cmd_type;

endpackage

/* sv/lru_open_page_tracker.sv */
// top level of the lru open page tracker: stream ports, controller and datapath
// depends on lopt_pkg, lopt_ctrl and lopt_datapath

// Tracks up to DEPTH (4) open pages in least recently used order, each keyed by
// entry id and page index. An open that hits moves the key to the newest place,
// an open that misses on a full list evicts and reports the oldest key, a close
// removes a matching key. Every request beat yields exactly one response beat,
// held in an output register. The compare over all slots and the shift of the
// list are done in the cycle the beat is accepted, and a new request is accepted
// in the same cycle the held response is taken, so the block sustains one request
// per cycle while responses are taken. The list is empty after reset with no
// clearing pass.
module lru_open_page_tracker
   import lopt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // entry_id[15:0], page_index[31:16]
   input  logic [0:0]  req_tuser,   // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // evicted_entry_id[15:0], evicted_page_index[31:16],
                                    // occupancy[34:32], zero[39:35]
   output logic [1:0]  rsp_tuser    // hit[0], evicted[1]
);

   cmd_type            cmd;
   opcode_type         opcode;
   logic               hit;
   logic               evicted;
   logic [FIELD_W-1:0] evicted_entry_id;
   logic [FIELD_W-1:0] evicted_page_index;
   logic [OCC_W-1:0]   occupancy;

   // request beat fields
   assign opcode = opcode_type'(req_tuser[0]);

   // handshake control
   lopt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // list and result register
   lopt_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .opcode             (opcode),
      .entry_id           (req_tdata[15:0]),
      .page_index         (req_tdata[31:16]),
      .hit                (hit),
      .evicted            (evicted),
      .evicted_entry_id   (evicted_entry_id),
      .evicted_page_index (evicted_page_index),
      .occupancy          (occupancy)
   );

   // response beat packing
   assign rsp_tdata = {5'b0, occupancy, evicted_page_index, evicted_entry_id};
   assign rsp_tuser = {evicted, hit};

endmodule

/* sv/lopt_ctrl.sv */
// controller of the lru open page tracker: beat handshakes and result register control
// depends on lopt_pkg
module lopt_ctrl
   import lopt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_EMPTY: begin
            if (req_tvalid) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_tready) begin
               state_in = req_tvalid ? ST_HOLD : ST_EMPTY;
            end
         end
         default: begin
            state_in = ST_EMPTY;
         end
      endcase
   end

   // outputs: a new beat is taken when the result register is empty or being drained
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_EMPTY: begin
            req_tready = 1'b1;
         end
         ST_HOLD: begin
            req_tready = rsp_tready;
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      cmd.load = req_tvalid & req_tready;
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/lopt_datapath.sv */
// datapath of the lru open page tracker: key slots, match, shift and result register
// depends on lopt_pkg and lru_open_page_tracker_macros.svh
`include "lru_open_page_tracker_macros.svh"

module lopt_datapath
   import lopt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  opcode_type         opcode,
   input  logic [FIELD_W-1:0] entry_id,
   input  logic [FIELD_W-1:0] page_index,
   output logic               hit,
   output logic               evicted,
   output logic [FIELD_W-1:0] evicted_entry_id,
   output logic [FIELD_W-1:0] evicted_page_index,
   output logic [OCC_W-1:0]   occupancy
);

   logic [KEY_W-1:0] slot_ff [DEPTH];
   logic [KEY_W-1:0] slot_in [DEPTH];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic               hit_ff;
   logic               evicted_ff;
   logic [KEY_W-1:0]   ev_key_ff;
   logic [OCC_W-1:0]   occ_ff;
   logic [OCC_W-1:0]   occ_in;

   logic [KEY_W-1:0]   key;
   logic [DEPTH-1:0]   match;
   logic               hit_c;
   logic [IDX_W-1:0]   hit_pos;
   logic               full;
   logic               evict_c;
   logic               remove;
   logic [IDX_W-1:0]   rm_pos;
   logic [CNT_W-1:0]   cnt_mid;
   logic               append;
   logic [KEY_W-1:0]   ev_key_c;
   logic [CNT_W+OCC_W-1:0] occ_wide;

   assign key = {entry_id, page_index};

   // associative compare over the valid slots
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match[i] = (CNT_W'(i) < count_ff) && (slot_ff[i] == key);
      end
   end

   // keys are unique in the list, so any matching slot is the one
   always_comb begin
      hit_pos = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_pos = IDX_W'(i);
         end
      end
   end

   // removal and append decisions
   assign hit_c    = |match;
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign evict_c  = !hit_c && (opcode == OP_OPEN) && full;
   assign remove   = hit_c || evict_c;
   assign rm_pos   = hit_c ? hit_pos : '0;
   assign cnt_mid  = remove ? (count_ff - CNT_W'(1)) : count_ff;
   assign append   = (opcode == OP_OPEN);
   assign count_in = append ? (cnt_mid + CNT_W'(1)) : cnt_mid;
   assign ev_key_c = evict_c ? slot_ff[0] : '0;

   // close the gap behind the removed slot, then place the new key at the tail
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (remove && (IDX_W'(i) >= rm_pos)) begin
            slot_in[i] = slot_ff[(i + 1 < DEPTH) ? i + 1 : i];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if (append && (cnt_mid == CNT_W'(i))) begin
            slot_in[i] = key;
         end
      end
   end

   // occupancy field, masked or zero extended to its width
   assign occ_wide = {{OCC_W{1'b0}}, count_in};
   assign occ_in   = occ_wide[OCC_W-1:0];

   // key slots, no reset: only slots below the count are ever read
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < DEPTH; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   // slot count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.load) begin
         count_ff <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hit_ff     <= hit_c;
         evicted_ff <= evict_c;
         ev_key_ff  <= ev_key_c;
         occ_ff     <= occ_in;
      end
   end

   assign hit                = hit_ff;
   assign evicted            = evicted_ff;
   assign evicted_entry_id   = ev_key_ff[KEY_W-1:FIELD_W];
   assign evicted_page_index = ev_key_ff[FIELD_W-1:0];
   assign occupancy          = occ_ff;

   // checks on the list bookkeeping
   `LOPT_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `LOPT_ASSERT(a_evict_keeps_full, clock, reset,
      (!reset && cmd.load && evict_c) |=> (count_ff == CNT_W'(DEPTH)))
   `LOPT_ASSERT(a_close_hit_shrinks, clock, reset,
      (!reset && cmd.load && hit_c && (opcode == OP_CLOSE))
         |=> (count_ff == $past(count_ff) - CNT_W'(1)))
   `LOPT_ASSERT(a_evict_only_on_miss, clock, reset, !(cmd.load && evict_c && hit_c))

endmodule

/* test/testbench.sv */
// self-checking testbench for the lru open page tracker: random and directed open/close beats
// depends on lopt_pkg and lru_open_page_tracker; keeps its own lru list to predict each response
module testbench;
   import lopt_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 16;
   localparam int RAND_ITEMS  = 1100;
   localparam int POOL_SIZE   = 6;

   // one request beat as the driver will present it
   typedef struct packed {
      opcode_type  op;
      logic [15:0] entry_id;
      logic [15:0] page_index;
      logic        drain_first;
   } page_request_type;

   // one response beat, field by field
   typedef struct packed {
      logic        hit;
      logic        evicted;
      logic [15:0] evicted_entry_id;
      logic [15:0] evicted_page_index;
      logic [2:0]  occupancy;
   } page_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   page_request_type requests_to_send[$];
   page_outcome_type outcomes_awaited[$];
   logic [31:0]      open_pages[$];          // predicted list, oldest first

   int  in_flight = 0;
   int  accepted_count = 0;
   int  cycle_count = 0;
   int  fail_count = 0;
   int  hit_total = 0;
   int  evict_total = 0;
   int  close_total = 0;
   logic calm;

   lru_open_page_tracker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // stretch of beats with no idling on either side
   assign calm = (accepted_count >= 400) && (accepted_count < 650);

   // lru list update for one request, returns the response it should produce
   function automatic page_outcome_type apply_request(opcode_type op, logic [15:0] eid,
                                                      logic [15:0] pidx);
      logic [31:0]      key;
      int               pos;
      page_outcome_type res;
      key = {eid, pidx};
      pos = -1;
      res = '0;
      for (int i = 0; i < open_pages.size(); i++) begin
         if (pos < 0 && open_pages[i] == key) pos = i;
      end
      if (pos >= 0) begin
         res.hit = 1'b1;
         open_pages.delete(pos);
      end else if (op == OP_OPEN && open_pages.size() >= DEPTH) begin
         res.evicted = 1'b1;
         {res.evicted_entry_id, res.evicted_page_index} = open_pages[0];
         open_pages.delete(0);
      end
      if (op == OP_OPEN && open_pages.size() < DEPTH) open_pages.insert(open_pages.size(), key);
      res.occupancy = 3'(open_pages.size());
      return res;
   endfunction

   task automatic add_request(opcode_type op, logic [15:0] eid, logic [15:0] pidx,
                              logic drain_first);
      page_request_type r;
      r.op          = op;
      r.entry_id    = eid;
      r.page_index  = pidx;
      r.drain_first = drain_first;
      requests_to_send.insert(requests_to_send.size(), r);
   endtask

   // request driver: predicts on every accepted beat, then picks the next one
   always @(posedge clock) begin
      page_outcome_type want;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            want = apply_request(opcode_type'(req_tuser[0]), req_tdata[15:0],
                                 req_tdata[31:16]);
            outcomes_awaited.insert(outcomes_awaited.size(), want);
            accepted_count <= accepted_count + 1;
            hit_total   += want.hit;
            evict_total += want.evicted;
            close_total += (req_tuser[0] == OP_CLOSE);
         end
         if (!req_tvalid || req_tready) begin
            if (requests_to_send.size() != 0
                && (calm || $urandom_range(99) >= IDLE_PCT)
                && !(requests_to_send[0].drain_first
                     && (in_flight != 0 || (req_tvalid && req_tready)))) begin
               req_tdata  <= {requests_to_send[0].page_index, requests_to_send[0].entry_id};
               req_tuser  <= requests_to_send[0].op;
               req_tvalid <= 1'b1;
               void'(requests_to_send.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // count of requests taken but not yet answered
   always @(posedge clock) begin
      if (!reset)
         in_flight <= in_flight + int'(req_tvalid && req_tready)
                      - int'(rsp_tvalid && rsp_tready);
   end

   // response monitor and checker
   always @(posedge clock) begin
      page_outcome_type got;
      page_outcome_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.hit                = rsp_tuser[0];
            got.evicted            = rsp_tuser[1];
            got.evicted_entry_id   = rsp_tdata[15:0];
            got.evicted_page_index = rsp_tdata[31:16];
            got.occupancy          = rsp_tdata[34:32];
            if (outcomes_awaited.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("response beat with nothing expected: %p", got);
            end else begin
               want = outcomes_awaited.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("response mismatch: expected %p, got %p", want, got);
               end
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // run length guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [31:0] key_pool[POOL_SIZE];
      logic [31:0] key;
      opcode_type  op;

      // directed part: edges of the fields, fill, hit, evict, close hit and miss
      add_request(OP_CLOSE, 16'h0000, 16'h0000, 1'b0);   // close on empty list
      add_request(OP_OPEN,  16'h0000, 16'h0000, 1'b0);
      add_request(OP_OPEN,  16'hffff, 16'hffff, 1'b0);
      add_request(OP_OPEN,  16'haaaa, 16'h5555, 1'b0);
      add_request(OP_OPEN,  16'h5555, 16'haaaa, 1'b0);   // list now full
      add_request(OP_OPEN,  16'h0000, 16'h0000, 1'b0);   // hit on the oldest
      add_request(OP_OPEN,  16'h1234, 16'h8001, 1'b0);   // evicts ffff/ffff
      add_request(OP_OPEN,  16'h1234, 16'h8001, 1'b0);   // hit on the newest
      add_request(OP_CLOSE, 16'haaaa, 16'h5555, 1'b0);   // close hit
      add_request(OP_CLOSE, 16'h0bad, 16'h0001, 1'b0);   // close miss
      add_request(OP_OPEN,  16'hffff, 16'h0000, 1'b1);   // append, after a full drain
      add_request(OP_OPEN,  16'h0000, 16'hffff, 1'b0);   // evict
      add_request(OP_OPEN,  16'h0000, 16'h0001, 1'b0);   // differs only in page index
      add_request(OP_OPEN,  16'h0001, 16'h0000, 1'b0);   // differs only in entry id
      add_request(OP_CLOSE, 16'h0001, 16'h0000, 1'b0);
      add_request(OP_CLOSE, 16'h0000, 16'h0001, 1'b0);
      add_request(OP_CLOSE, 16'h0000, 16'hffff, 1'b0);
      add_request(OP_CLOSE, 16'hffff, 16'h0000, 1'b0);   // list empty again
      add_request(OP_OPEN,  16'h8000, 16'h0001, 1'b0);
      add_request(OP_CLOSE, 16'h8000, 16'h0001, 1'b0);   // open then close same key

      // random part: mostly keys from a small pool so hits and evictions are common
      foreach (key_pool[i]) key_pool[i] = $urandom;
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n % 90 == 0) key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
         if ($urandom_range(99) < 75) key = key_pool[$urandom_range(POOL_SIZE - 1)];
         else key = $urandom;
         op = ($urandom_range(99) < 30) ? OP_CLOSE : OP_OPEN;
         add_request(op, key[31:16], key[15:0], (n % 250 == 125));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (requests_to_send.size() != 0 || req_tvalid || outcomes_awaited.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);

      $display("%0d requests checked: %0d hits, %0d evictions, %0d close requests",
               accepted_count, hit_total, evict_total, close_total);
      $display("idle and stall cycles on both channels, with several full drains between beats");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* lru_open_page_tracker.f */
+incdir+sv
sv/lopt_pkg.sv
sv/lopt_ctrl.sv
sv/lopt_datapath.sv
sv/lru_open_page_tracker.sv
test/testbench.sv
